[rtl/priority_ready_queue_scheduler_defines.svh]
// Assertion helpers for the scheduler.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_DEFINES_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_DEFINES_SVH

// Same-cycle implication.
`define PRQS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PRQS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/prqs_pkg.sv]
package prqs_pkg;

   localparam int ID_W       = 5;
   localparam int ACT_W      = 2;
   localparam int LVL_W      = 2;
   localparam int DATA_W     = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [ACT_W-1:0] ACT_READY  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_CHOOSE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_YIELD  = 2'd2;
   localparam logic [ACT_W-1:0] ACT_NONE   = 2'd3;

   localparam logic [0:0] REG_IDLE_PROCESS = 1'b0;

   typedef struct packed {
      logic cap;
      logic enq;
      logic pick;
      logic link;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic [ACT_W-1:0] new_action;
   } status_type;

endpackage

[rtl/prqs_if.sv]
interface prqs_req_if;
   logic                        valid;
   logic                        ready;
   logic [prqs_pkg::ACT_W-1:0]  action;
   logic [prqs_pkg::ID_W-1:0]   process_id;
   logic [prqs_pkg::LVL_W-1:0]  level;

   modport source (output valid, action, process_id, level, input ready);
   modport sink   (input valid, action, process_id, level, output ready);
endinterface

interface prqs_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [prqs_pkg::ID_W-1:0]  running_id;
   logic                       is_idle;

   modport source (output valid, running_id, is_idle, input ready);
   modport sink   (input valid, running_id, is_idle, output ready);
endinterface

[rtl/prqs_ctrl.sv]
module prqs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output prqs_pkg::cmd_type    cmd,
   input  prqs_pkg::status_type status
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ENQ  = 2'd1;
   localparam logic [1:0] S_PICK = 2'd2;
   localparam logic [1:0] S_LINK = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       pending_ff, pending_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       done;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && (!pending_ff || out_free);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd       = '0;
      cmd.cap   = req_valid && req_ready;
      cmd.load  = (state_ff == S_IDLE) && pending_ff && out_free;
      cmd.enq   = (state_ff == S_ENQ);
      cmd.pick  = (state_ff == S_PICK);
      cmd.link  = (state_ff == S_LINK);
      done      = 1'b0;
      state_in  = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.cap) begin
               state_in = (status.new_action == prqs_pkg::ACT_CHOOSE) ? S_PICK : S_ENQ;
            end
         end
         S_ENQ: begin
            if (status.action == prqs_pkg::ACT_YIELD) begin
               state_in = S_PICK;
            end else begin
               state_in = S_IDLE;
               done     = 1'b1;
            end
         end
         S_PICK: begin
            state_in = S_LINK;
         end
         S_LINK: begin
            state_in = S_IDLE;
            done     = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      pending_in   = done || (pending_ff && !cmd.load);
      rsp_valid_in = cmd.load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/prqs_datapath.sv]
module prqs_datapath #(
   parameter int NUM_PROCESSES = 32,
   parameter int NUM_LEVELS    = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  prqs_pkg::cmd_type             cmd,
   output prqs_pkg::status_type          status,
   input  logic [prqs_pkg::ACT_W-1:0]    req_action,
   input  logic [prqs_pkg::ID_W-1:0]     req_process_id,
   input  logic [prqs_pkg::LVL_W-1:0]    req_level,
   input  logic [prqs_pkg::ID_W-1:0]     idle_process,
   output logic [prqs_pkg::ID_W-1:0]     running_id,
   output logic                          is_idle
);

   localparam int ID_W    = prqs_pkg::ID_W;
   localparam int IDX_W   = $clog2(NUM_PROCESSES);
   localparam int PWIDE_W = (IDX_W > ID_W) ? IDX_W : ID_W;
   localparam int LIDX_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int LWIDE_W = (LIDX_W > prqs_pkg::LVL_W) ? LIDX_W : prqs_pkg::LVL_W;

   // item
   logic [prqs_pkg::ACT_W-1:0] action_ff, action_in;
   logic [ID_W-1:0]            pid_ff, pid_in;
   logic [prqs_pkg::LVL_W-1:0] lvl_ff, lvl_in;

   // queue state
   logic [NUM_LEVELS-1:0] nonempty_ff, nonempty_in;
   logic [ID_W-1:0]       head_ff [NUM_LEVELS];
   logic [ID_W-1:0]       head_in [NUM_LEVELS];
   logic [ID_W-1:0]       tail_ff [NUM_LEVELS];
   logic [ID_W-1:0]       tail_in [NUM_LEVELS];
   logic [ID_W-1:0]       current_ff, current_in;
   logic                  cur_idle_ff, cur_idle_in;
   logic [LIDX_W-1:0]     sel_ff, sel_in;
   logic                  hit_ff, hit_in;
   logic [ID_W-1:0]       running_ff, running_in;
   logic                  is_idle_ff, is_idle_in;

   // link table
   logic [ID_W-1:0]  next_link [NUM_PROCESSES];
   logic [ID_W-1:0]  link_rd_ff;
   logic             link_we;

   logic [ID_W-1:0]    enq_pid;
   logic [PWIDE_W-1:0] enq_wide, tail_wide, head_wide;
   logic [LWIDE_W-1:0] lvl_wide;
   logic [LIDX_W-1:0]  lvl_idx, sel, lvl_addr;
   logic [ID_W-1:0]    head_rd, tail_rd;
   logic               found, enq_act, enq_ok, tail_ok, head_ok, empties;

   assign status.action     = action_ff;
   assign status.new_action = req_action;
   assign running_id        = running_ff;
   assign is_idle           = is_idle_ff;

   assign enq_pid   = (action_ff == prqs_pkg::ACT_READY) ? pid_ff : current_ff;
   assign enq_wide  = PWIDE_W'(enq_pid);
   assign lvl_wide  = LWIDE_W'(lvl_ff);
   assign lvl_idx   = lvl_wide[LIDX_W-1:0];
   assign lvl_addr  = cmd.pick ? sel : lvl_idx;
   assign head_rd   = head_ff[lvl_addr];
   assign tail_rd   = tail_ff[lvl_addr];
   assign tail_wide = PWIDE_W'(tail_rd);
   assign head_wide = PWIDE_W'(head_rd);
   assign tail_ok   = 32'(tail_rd) < NUM_PROCESSES;
   assign head_ok   = 32'(head_rd) < NUM_PROCESSES;
   assign empties   = (head_rd == tail_rd) || !head_ok;

   always_comb begin
      enq_act = action_ff inside {prqs_pkg::ACT_READY, prqs_pkg::ACT_YIELD};
      enq_ok  = enq_act && (32'(lvl_ff) < NUM_LEVELS) && (32'(enq_pid) < NUM_PROCESSES);
   end

   // highest-priority non-empty level
   always_comb begin
      found = 1'b0;
      sel   = '0;
      for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
         if (nonempty_ff[l]) begin
            found = 1'b1;
            sel   = LIDX_W'(l);
         end
      end
   end

   assign link_we = cmd.enq && enq_ok && nonempty_ff[lvl_idx] && tail_ok;

   always_comb begin
      action_in   = action_ff;
      pid_in      = pid_ff;
      lvl_in      = lvl_ff;
      nonempty_in = nonempty_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      current_in  = current_ff;
      cur_idle_in = cur_idle_ff;
      sel_in      = sel_ff;
      hit_in      = hit_ff;
      running_in  = running_ff;
      is_idle_in  = is_idle_ff;
      if (cmd.cap) begin
         action_in = req_action;
         pid_in    = req_process_id;
         lvl_in    = req_level;
      end
      if (cmd.enq && enq_ok) begin
         if (!nonempty_ff[lvl_idx]) begin
            head_in[lvl_idx]     = enq_pid;
            nonempty_in[lvl_idx] = 1'b1;
         end
         tail_in[lvl_idx] = enq_pid;
      end
      if (cmd.pick) begin
         sel_in = sel;
         hit_in = found && !empties;
         if (found) begin
            current_in  = head_rd;
            cur_idle_in = 1'b0;
            if (empties) begin
               nonempty_in[sel] = 1'b0;
            end
         end else begin
            current_in  = idle_process;
            cur_idle_in = 1'b1;
         end
      end
      if (cmd.link && hit_ff) begin
         head_in[sel_ff] = link_rd_ff;
      end
      if (cmd.load) begin
         running_in = current_ff;
         is_idle_in = cur_idle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nonempty_ff <= '0;
         current_ff  <= '0;
         cur_idle_ff <= 1'b1;
         hit_ff      <= 1'b0;
      end else begin
         nonempty_ff <= nonempty_in;
         current_ff  <= current_in;
         cur_idle_ff <= cur_idle_in;
         hit_ff      <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff  <= action_in;
      pid_ff     <= pid_in;
      lvl_ff     <= lvl_in;
      head_ff    <= head_in;
      tail_ff    <= tail_in;
      sel_ff     <= sel_in;
      running_ff <= running_in;
      is_idle_ff <= is_idle_in;
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         next_link[tail_wide[IDX_W-1:0]] <= enq_wide[ID_W-1:0];
      end
      if (cmd.pick) begin
         link_rd_ff <= next_link[head_wide[IDX_W-1:0]];
      end
   end

endmodule

[rtl/priority_ready_queue_scheduler.sv]
// Priority ready-queue scheduler.
// req_chan (valid/ready) carries one scheduling beat: action 0 readies
// process_id at level, action 1 picks the next process, action 2 readies the
// running process at level and then picks. Level 0 is the highest priority;
// levels at or above NUM_LEVELS are the idle level and are not queued.
// rsp_chan returns one beat per request: the running process and is_idle.
// csr port: register 0 at byte 0 holds the idle process, written with an
// APB setup/access pair; pready is tied high.
// The sequencer runs one item at a time and takes no new request until it is
// back in idle: action 0 or 3 runs an enqueue step, action 1 a pick and a
// link step, action 2 an enqueue, pick and link step; the link step applies
// the pick's registered read of the link table to the head of the level.
// A finished result waits in the output register while the next request is
// taken; a second result then holds the sequencer until rsp_chan drains.
// Reset (synchronous) empties every queue, makes process 0 the current idle
// process and clears the idle process register. Link table is not cleared.
`include "priority_ready_queue_scheduler_defines.svh"

module priority_ready_queue_scheduler #(
   parameter int NUM_PROCESSES = 32,
   parameter int NUM_LEVELS    = 3
) (
   input  logic                                clock,
   input  logic                                reset,
   prqs_req_if.sink                            req_chan,
   prqs_rsp_if.source                          rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [prqs_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [prqs_pkg::DATA_W-1:0]         csr_pwdata,
   output logic [prqs_pkg::DATA_W-1:0]         csr_prdata,
   output logic                                csr_pready
);

   prqs_pkg::cmd_type    cmd;
   prqs_pkg::status_type status;

   logic [prqs_pkg::ID_W-1:0] idle_process_ff, idle_process_in;
   logic                      csr_hit, csr_wr;

   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[prqs_pkg::CSR_ADDR_W-1:2] == prqs_pkg::REG_IDLE_PROCESS;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign csr_prdata = csr_hit ? prqs_pkg::DATA_W'(idle_process_ff) : '0;

   assign idle_process_in = csr_wr ? csr_pwdata[prqs_pkg::ID_W-1:0] : idle_process_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_process_ff <= '0;
      end else begin
         idle_process_ff <= idle_process_in;
      end
   end

   prqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   prqs_datapath #(
      .NUM_PROCESSES (NUM_PROCESSES),
      .NUM_LEVELS    (NUM_LEVELS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_action     (req_chan.action),
      .req_process_id (req_chan.process_id),
      .req_level      (req_chan.level),
      .idle_process   (idle_process_ff),
      .running_id     (rsp_chan.running_id),
      .is_idle        (rsp_chan.is_idle)
   );

   `PRQS_ASSERT_NEXT(a_busy_after_accept, clock, reset,
      req_chan.valid && req_chan.ready, !req_chan.ready, "accepted a beat while busy")
   `PRQS_ASSERT_NEXT(a_pick_then_link, clock, reset,
      cmd.pick, cmd.link, "pick not followed by link update")
   `PRQS_ASSERT_NOW(a_load_when_free, clock, reset,
      cmd.load, !rsp_chan.valid || rsp_chan.ready, "result overwrote a pending beat")
   `PRQS_ASSERT_NOW(a_one_step, clock, reset,
      1'b1, $onehot0({cmd.cap, cmd.enq, cmd.pick, cmd.link}), "overlapping sequencer steps")

endmodule

[sim/tb_priority_ready_queue_scheduler.sv]
module tb_priority_ready_queue_scheduler;

   localparam int ID_W       = prqs_pkg::ID_W;
   localparam int ACT_W      = prqs_pkg::ACT_W;
   localparam int LVL_W      = prqs_pkg::LVL_W;
   localparam int DATA_W     = prqs_pkg::DATA_W;
   localparam int CSR_ADDR_W = prqs_pkg::CSR_ADDR_W;

   localparam int NPROC       = 32;
   localparam int NLVL        = 3;
   localparam int STALL_LIMIT = 1000;
   localparam int HOLD_AT     = 150;
   localparam int HOLD_CYCLES = 48;
   localparam int MAX_REPORTS = 10;

   localparam logic [LVL_W-1:0]      IDLE_LEVEL    = LVL_W'(NLVL);
   localparam logic [CSR_ADDR_W-1:0] IDLE_PID_ADDR =
      CSR_ADDR_W'(4 * int'(prqs_pkg::REG_IDLE_PROCESS));

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic [ID_W-1:0]  process_id;
      logic [LVL_W-1:0] level;
   } sched_req_type;

   typedef struct packed {
      logic [ID_W-1:0] running_id;
      logic            is_idle;
   } sched_rsp_type;

   // queued[] is bookkeeping for legal stimulus, not block state
   typedef struct packed {
      logic [NPROC-1:0][ID_W-1:0] next_link;
      logic [NLVL-1:0][ID_W-1:0]  head;
      logic [NLVL-1:0][ID_W-1:0]  tail;
      logic [NLVL-1:0]            nonempty;
      logic [NPROC-1:0]           queued;
      logic [ID_W-1:0]            cur_id;
      logic                       cur_idle;
      logic [ID_W-1:0]            idle_pid;
   } sched_state_type;

   logic clock;
   logic reset = 1'b1;

   logic              req_valid  = 1'b0;
   logic [ACT_W-1:0]  req_action = prqs_pkg::ACT_NONE;
   logic [ID_W-1:0]   req_pid    = '0;
   logic [LVL_W-1:0]  req_level  = '0;
   logic              rsp_ready  = 1'b0;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [DATA_W-1:0]     csr_pwdata  = '0;
   logic [DATA_W-1:0]     csr_prdata;
   logic                  csr_pready;

   prqs_req_if req_bus();
   prqs_rsp_if rsp_bus();

   assign req_bus.valid      = req_valid;
   assign req_bus.action     = req_action;
   assign req_bus.process_id = req_pid;
   assign req_bus.level      = req_level;
   assign rsp_bus.ready      = rsp_ready;

   priority_ready_queue_scheduler #(
      .NUM_PROCESSES(NPROC),
      .NUM_LEVELS   (NLVL)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_bus),
      .rsp_chan   (rsp_bus),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   sched_req_type   pending_reqs[$];
   sched_rsp_type   expected_runs[$];
   sched_state_type sched_model;
   sched_state_type gen_state;
   sched_req_type   next_beat;
   sched_req_type   taken_beat;
   sched_rsp_type   due_run;
   sched_rsp_type   new_run;

   logic req_fire  = 1'b0;
   logic steady    = 1'b0;
   logic hold_done = 1'b0;
   int   req_gap   = 0;
   int   rsp_gap   = 0;
   int   hold_left = 0;

   int quiet_cycles = 0;
   int results_seen = 0;
   int idle_results = 0;
   int mismatches   = 0;
   int deepest      = 0;
   int beats_by_act[4] = '{0, 0, 0, 0};

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic sched_state_type fresh_state();
      sched_state_type s;
      s          = '0;
      s.cur_idle = 1'b1;
      return s;
   endfunction

   function automatic sched_state_type ready_proc(sched_state_type s,
                                                  logic [ID_W-1:0] pid,
                                                  logic [LVL_W-1:0] lvl);
      if (lvl < NLVL) begin
         if (s.nonempty[lvl]) begin
            s.next_link[s.tail[lvl]] = pid;
         end else begin
            s.head[lvl]     = pid;
            s.nonempty[lvl] = 1'b1;
         end
         s.tail[lvl]    = pid;
         s.queued[pid]  = 1'b1;
      end
      return s;
   endfunction

   function automatic sched_state_type pick_next(sched_state_type s);
      logic            found;
      logic [ID_W-1:0] h;
      int              l;
      found = 1'b0;
      for (l = 0; l < NLVL; l++) begin
         if (!found && s.nonempty[l]) begin
            found       = 1'b1;
            h           = s.head[l];
            s.cur_id    = h;
            s.cur_idle  = 1'b0;
            s.queued[h] = 1'b0;
            if (h == s.tail[l]) begin
               s.nonempty[l] = 1'b0;
            end else begin
               s.head[l] = s.next_link[h];
            end
         end
      end
      if (!found) begin
         s.cur_id   = s.idle_pid;
         s.cur_idle = 1'b1;
      end
      return s;
   endfunction

   function automatic sched_state_type apply_beat(sched_state_type s, sched_req_type r);
      case (r.action)
         prqs_pkg::ACT_READY:  s = ready_proc(s, r.process_id, r.level);
         prqs_pkg::ACT_CHOOSE: s = pick_next(s);
         prqs_pkg::ACT_YIELD:  s = pick_next(ready_proc(s, s.cur_id, r.level));
         default:    ;
      endcase
      return s;
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("mismatch: %s", msg);
      end
   endfunction

   // never ready a process that is already queued
   task automatic offer(input logic [ACT_W-1:0] act, input logic [ID_W-1:0] pid,
                        input logic [LVL_W-1:0] lvl);
      sched_req_type beat;
      logic          found;
      int            start;
      int            i;
      if (act == prqs_pkg::ACT_READY && lvl < NLVL && gen_state.queued[pid]) begin
         found = 1'b0;
         start = $urandom_range(0, NPROC - 1);
         for (i = 0; i < NPROC; i++) begin
            if (!found && !gen_state.queued[ID_W'((start + i) % NPROC)]) begin
               pid   = ID_W'((start + i) % NPROC);
               found = 1'b1;
            end
         end
         if (!found) begin
            lvl = IDLE_LEVEL;
         end
      end
      if (act == prqs_pkg::ACT_YIELD && lvl < NLVL && gen_state.queued[gen_state.cur_id]) begin
         lvl = IDLE_LEVEL;
      end
      beat.action     = act;
      beat.process_id = pid;
      beat.level      = lvl;
      gen_state = apply_beat(gen_state, beat);
      if ($countones(gen_state.queued) > deepest) begin
         deepest = $countones(gen_state.queued);
      end
      pending_reqs.push_back(beat);
   endtask

   // bursts lean toward filling, draining or a mix
   task automatic offer_random(input int count);
      int               burst;
      int               mood;
      int               roll;
      int               n;
      logic [ACT_W-1:0] act;
      logic [LVL_W-1:0] lvl;
      burst = 0;
      mood  = 0;
      for (n = 0; n < count; n++) begin
         if (burst == 0) begin
            burst = $urandom_range(8, 40);
            mood  = $urandom_range(0, 2);
         end
         burst--;
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            act = prqs_pkg::ACT_NONE;
         end else if (roll < (mood == 0 ? 75 : (mood == 1 ? 25 : 50))) begin
            act = prqs_pkg::ACT_READY;
         end else if ($urandom_range(0, 1) == 0) begin
            act = prqs_pkg::ACT_CHOOSE;
         end else begin
            act = prqs_pkg::ACT_YIELD;
         end
         lvl = ($urandom_range(0, 11) == 0) ? IDLE_LEVEL : LVL_W'($urandom_range(0, NLVL - 1));
         offer(act, ID_W'($urandom_range(0, NPROC - 1)), lvl);
      end
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || expected_runs.size() != 0 || req_valid) begin
         @(posedge clock);
      end
   endtask

   // write then read back; the monitor tracks and checks both
   task automatic write_idle_pid(input logic [ID_W-1:0] value);
      @(negedge clock);
      csr_psel               = 1'b1;
      csr_penable            = 1'b0;
      csr_pwrite             = 1'b1;
      csr_paddr              = IDLE_PID_ADDR;
      csr_pwdata             = $urandom;
      csr_pwdata[ID_W-1:0]   = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      gen_state.idle_pid = value;
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fire) begin
         // beat still waiting for ready
      end else if (req_gap > 0) begin
         req_gap--;
         req_valid <= 1'b0;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
         req_gap = $urandom_range(0, 2);
         req_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
         next_beat = pending_reqs.pop_front();
         req_valid  <= 1'b1;
         req_action <= next_beat.action;
         req_pid    <= next_beat.process_id;
         req_level  <= next_beat.level;
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
         rsp_gap = $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      req_fire = 1'b0;
      if (reset) begin
         sched_model = fresh_state();
      end else begin
         quiet_cycles++;
         if (csr_psel && csr_penable && csr_pready && csr_paddr == IDLE_PID_ADDR) begin
            if (csr_pwrite) begin
               sched_model.idle_pid = csr_pwdata[ID_W-1:0];
            end else if (csr_prdata[ID_W-1:0] !== sched_model.idle_pid) begin
               note_mismatch($sformatf("idle_process readback: expected %0d, got %0d",
                                       sched_model.idle_pid, csr_prdata[ID_W-1:0]));
            end
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            quiet_cycles = 0;
            results_seen++;
            if (expected_runs.size() == 0) begin
               note_mismatch($sformatf("unexpected beat: running_id %0d is_idle %0d",
                                       rsp_bus.running_id, rsp_bus.is_idle));
            end else begin
               due_run = expected_runs.pop_front();
               if (rsp_bus.running_id !== due_run.running_id ||
                   rsp_bus.is_idle !== due_run.is_idle) begin
                  note_mismatch($sformatf(
                     "result %0d: expected running_id %0d is_idle %0d, got %0d %0d",
                     results_seen, due_run.running_id, due_run.is_idle,
                     rsp_bus.running_id, rsp_bus.is_idle));
               end
               if (due_run.is_idle) begin
                  idle_results++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            quiet_cycles = 0;
            req_fire     = 1'b1;
            taken_beat.action     = req_bus.action;
            taken_beat.process_id = req_bus.process_id;
            taken_beat.level      = req_bus.level;
            sched_model = apply_beat(sched_model, taken_beat);
            new_run.running_id = sched_model.cur_id;
            new_run.is_idle    = sched_model.cur_idle;
            expected_runs.push_back(new_run);
            beats_by_act[taken_beat.action]++;
         end
      end
   end

   always @(negedge clock) begin
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no beat for %0d cycles, %0d results outstanding",
                  quiet_cycles, expected_runs.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      gen_state = fresh_state();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // idle process still at its reset value
      offer(prqs_pkg::ACT_CHOOSE, 5'd0, 2'd0);
      offer(prqs_pkg::ACT_NONE, 5'd31, IDLE_LEVEL);
      offer(prqs_pkg::ACT_READY, 5'd31, 2'd0);
      offer(prqs_pkg::ACT_READY, 5'd0, 2'd2);
      offer(prqs_pkg::ACT_READY, 5'd5, 2'd1);
      offer(prqs_pkg::ACT_READY, 5'd7, IDLE_LEVEL);
      offer(prqs_pkg::ACT_READY, 5'd9, 2'd0);
      offer(prqs_pkg::ACT_NONE, 5'd0, 2'd0);
      offer(prqs_pkg::ACT_CHOOSE, 5'd0, 2'd0);
      offer(prqs_pkg::ACT_CHOOSE, 5'd31, 2'd3);
      offer(prqs_pkg::ACT_CHOOSE, 5'd0, 2'd0);
      offer(prqs_pkg::ACT_YIELD, 5'd0, 2'd2);
      offer(prqs_pkg::ACT_YIELD, 5'd0, 2'd0);
      offer(prqs_pkg::ACT_YIELD, 5'd0, IDLE_LEVEL);
      offer(prqs_pkg::ACT_CHOOSE, 5'd0, 2'd0);
      offer(prqs_pkg::ACT_READY, 5'd20, 2'd1);
      offer(prqs_pkg::ACT_NONE, 5'd0, 2'd0);
      offer(prqs_pkg::ACT_CHOOSE, 5'd0, 2'd0);
      offer(prqs_pkg::ACT_YIELD, 5'd0, 2'd1);
      offer(prqs_pkg::ACT_CHOOSE, 5'd0, 2'd0);
      wait_drained();

      write_idle_pid(5'd31);
      offer_random(300);
      wait_drained();

      write_idle_pid(ID_W'($urandom_range(1, 30)));
      offer_random(300);
      wait_drained();

      write_idle_pid(5'd0);
      offer_random(300);
      wait_drained();

      write_idle_pid(ID_W'($urandom));
      steady = 1'b1;
      offer_random(300);
      wait_drained();
      repeat (8) @(posedge clock);

      $display("run: %0d beats (ready %0d, choose %0d, yield %0d, no-op %0d), %0d results",
               beats_by_act[0] + beats_by_act[1] + beats_by_act[2] + beats_by_act[3],
               beats_by_act[prqs_pkg::ACT_READY], beats_by_act[prqs_pkg::ACT_CHOOSE],
               beats_by_act[prqs_pkg::ACT_YIELD], beats_by_act[prqs_pkg::ACT_NONE],
               results_seen);
      $display("run: %0d idle picks, up to %0d processes queued, %0d mismatches",
               idle_results, deepest, mismatches);
      if (mismatches == 0 && expected_runs.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/prqs_pkg.sv
rtl/prqs_if.sv
rtl/prqs_ctrl.sv
rtl/prqs_datapath.sv
rtl/priority_ready_queue_scheduler.sv
sim/tb_priority_ready_queue_scheduler.sv
